FILE: hw/rtl/pll_pkg.sv
// Package with shared constants and types for the pooled linked list engine.
package pll_pkg;

  localparam int PoolNodesDefault = 64;

  // Command codes.
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_REMOVE     = 3'd2;
  localparam logic [2:0] ACT_FIND       = 3'd3;
  localparam logic [2:0] ACT_REVERSE    = 3'd4;
  localparam logic [2:0] ACT_PEEK       = 3'd5;

  // One classified command as it travels from the front part to the back part.
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] item_char;
  } pll_cmd_t;

endpackage

FILE: hw/rtl/pll_ram.sv
// Generic single-port RAM with registered read.
module pll_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Read before write; a read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hw/rtl/pll_front.sv
// Front part: takes commands and holds them in a two-entry queue.
module pll_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        action,
  input  logic [7:0]        item_char,
  output logic              busy,
  output logic              cmd_valid,
  output pll_pkg::pll_cmd_t cmd,
  input  logic              cmd_take
);
  import pll_pkg::*;

  pll_cmd_t   slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign busy      = (fill == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{action: action, item_char: item_char};
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, cmd_take};
    end
  end
endmodule

FILE: hw/rtl/pll_back.sv
// Back part: walks and edits the node pool for one command at a time.
module pll_back #(
  parameter int PoolNodes = pll_pkg::PoolNodesDefault,
  localparam int AW = $clog2(PoolNodes),
  localparam int LW = $clog2(PoolNodes + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  pll_pkg::pll_cmd_t cmd,
  output logic              cmd_take,
  output logic              done,
  output logic              ok,
  output logic              hit,
  output logic [7:0]        first_item,
  output logic              non_empty,
  output logic [6:0]        item_count
);
  import pll_pkg::*;

  localparam logic [LW-1:0] NullLink = LW'(PoolNodes);

  // Sequencer states.
  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_WAIT  = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_WR1   = 4'd5;
  localparam logic [3:0] S_WR2   = 4'd6;
  localparam logic [3:0] S_HEAD  = 4'd7;
  localparam logic [3:0] S_HWAIT = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]    state;
  pll_cmd_t      cur_cmd;
  logic [LW-1:0] head, free_idx, cur, prev, count, steps;
  logic          ok_r, hit_r;

  // Memory ports.
  logic [AW-1:0] addr;
  logic [7:0]    item_wd, item_rd;
  logic [LW-1:0] link_wd, link_rd;
  logic          item_we, link_we;

  pll_ram #(.Width(8), .Depth(PoolNodes)) u_items (
    .clk(clk), .we(item_we), .addr(addr), .wdata(item_wd), .rdata(item_rd));
  pll_ram #(.Width(LW), .Depth(PoolNodes)) u_links (
    .clk(clk), .we(link_we), .addr(addr), .wdata(link_wd), .rdata(link_rd));

  logic cur_ok, link_ok;
  assign cur_ok  = (cur < NullLink) && (steps < NullLink);
  assign link_ok = link_rd < NullLink;

  // Pending writes, set up while evaluating.
  logic [AW-1:0] w1_addr, w2_addr;
  logic [LW-1:0] w1_link, w2_link;
  logic [7:0]    w1_item;
  logic          w1_item_en, w2_en;

  // Memory port control.
  always_comb begin
    addr    = cur[AW-1:0];
    item_we = 1'b0;
    link_we = 1'b0;
    item_wd = w1_item;
    link_wd = w1_link;
    unique case (state)
      S_INIT: begin
        link_we = 1'b1;
        link_wd = cur + LW'(1);
      end
      S_WR1: begin
        addr    = w1_addr;
        link_we = 1'b1;
        item_we = w1_item_en;
      end
      S_WR2: begin
        addr    = w2_addr;
        link_we = w2_en;
        link_wd = w2_link;
      end
      // Keep the head addressed so its item is on the read port at the result.
      S_HEAD, S_HWAIT: addr = head[AW-1:0];
      default: ;
    endcase
  end

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign done     = (state == S_OUT);
  assign ok       = ok_r;
  assign hit      = hit_r;
  assign non_empty  = head < NullLink;
  assign first_item = non_empty ? item_rd : 8'd0;
  assign item_count = 7'(count);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      cur      <= '0;
      head     <= NullLink;
      free_idx <= '0;
      count    <= '0;
      ok_r     <= 1'b0;
      hit_r    <= 1'b0;
      w2_en    <= 1'b0;
    end else begin
      unique case (state)
        // Clearing pass: chain every node onto the free list.
        S_INIT: begin
          cur <= cur + LW'(1);
          if (cur == NullLink - LW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur_cmd <= cmd;
            ok_r    <= 1'b1;
            hit_r   <= 1'b0;
            prev    <= NullLink;
            steps   <= '0;
            w2_en   <= 1'b0;
            unique case (cmd.action)
              ACT_PUSH_FRONT: begin
                cur   <= free_idx;
                state <= S_RD;
              end
              ACT_PUSH_BACK, ACT_REMOVE, ACT_FIND, ACT_REVERSE: begin
                cur   <= head;
                state <= S_RD;
              end
              default: state <= S_HEAD;
            endcase
          end
        end
        S_RD: begin
          if (cur_cmd.action == ACT_PUSH_FRONT ||
              (cur_cmd.action == ACT_PUSH_BACK && head >= NullLink)) begin
            // Take the free node at the front.
            if (free_idx >= NullLink) begin
              ok_r  <= 1'b0;
              state <= S_HEAD;
            end else begin
              cur   <= free_idx;
              state <= S_WAIT;
            end
          end else if (!cur_ok) begin
            if (cur_cmd.action == ACT_REMOVE) begin
              ok_r <= 1'b0;
            end
            if (cur_cmd.action == ACT_REVERSE && prev < NullLink) begin
              head <= prev;
            end
            state <= S_HEAD;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_EVAL;
        S_EVAL: begin
          if (cur_cmd.action == ACT_PUSH_FRONT ||
              (cur_cmd.action == ACT_PUSH_BACK && head >= NullLink)) begin
            free_idx   <= link_rd;
            w1_addr    <= cur[AW-1:0];
            w1_item    <= cur_cmd.item_char;
            w1_item_en <= 1'b1;
            w1_link    <= head;
            head       <= cur;
            count      <= count + LW'(1);
            state      <= S_WR1;
          end else begin
            unique case (cur_cmd.action)
              ACT_PUSH_BACK: begin
                if (link_ok && steps < NullLink - LW'(1)) begin
                  cur   <= link_rd;
                  steps <= steps + LW'(1);
                  state <= S_RD;
                end else if (free_idx >= NullLink) begin
                  ok_r  <= 1'b0;
                  state <= S_HEAD;
                end else begin
                  // Tail found: new node, then link tail to it.
                  w2_addr    <= cur[AW-1:0];
                  w2_link    <= free_idx;
                  w2_en      <= 1'b1;
                  cur        <= free_idx;
                  steps      <= NullLink;
                  cur_cmd.action <= ACT_PEEK;
                  state      <= S_WAIT;
                end
              end
              ACT_PEEK: begin
                // Second pass of push back: the free node is read now.
                free_idx   <= link_rd;
                w1_addr    <= cur[AW-1:0];
                w1_item    <= cur_cmd.item_char;
                w1_item_en <= 1'b1;
                w1_link    <= NullLink;
                count      <= count + LW'(1);
                state      <= S_WR1;
              end
              ACT_REMOVE: begin
                if (item_rd == cur_cmd.item_char) begin
                  if (prev < NullLink) begin
                    w2_addr <= prev[AW-1:0];
                    w2_link <= link_rd;
                    w2_en   <= 1'b1;
                  end else begin
                    head <= link_rd;
                  end
                  w1_addr    <= cur[AW-1:0];
                  w1_item    <= 8'd0;
                  w1_item_en <= 1'b1;
                  w1_link    <= free_idx;
                  free_idx   <= cur;
                  count      <= count - LW'(1);
                  state      <= S_WR1;
                end else begin
                  prev  <= cur;
                  cur   <= link_rd;
                  steps <= steps + LW'(1);
                  state <= S_RD;
                end
              end
              ACT_FIND: begin
                if (item_rd == cur_cmd.item_char) begin
                  hit_r <= 1'b1;
                  state <= S_HEAD;
                end else begin
                  cur   <= link_rd;
                  steps <= steps + LW'(1);
                  state <= S_RD;
                end
              end
              default: begin
                // Reverse: point this node back at the previous one.
                w1_addr    <= cur[AW-1:0];
                w1_item_en <= 1'b0;
                w1_link    <= prev;
                prev       <= cur;
                cur        <= link_rd;
                steps      <= steps + LW'(1);
                state      <= S_WR1;
              end
            endcase
          end
        end
        S_WR1: begin
          if (cur_cmd.action == ACT_REVERSE) begin
            state <= S_RD;
          end else begin
            state <= S_WR2;
          end
        end
        S_WR2: begin
          w2_en <= 1'b0;
          state <= S_HEAD;
        end
        S_HEAD:  state <= S_HWAIT;
        S_HWAIT: state <= S_OUT;
        S_OUT:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/pooled_linked_list_engine_unit.sv
// Top level of the pooled linked list engine.
//
// A command (action, item_char) is transferred at a rising edge with start
// high and busy low. A two-entry queue holds commands while the list
// sequencer works, so busy rises only when the queue is full.
// Each command yields one result (ok, hit, first_item, non_empty,
// item_count), shown for one cycle with done high; the receiver cannot
// stall it.
// The sequencer visits one node at a time through single-port pool
// memories: each node is read (S_RD, S_WAIT) and evaluated (S_EVAL), and
// edits are written in S_WR1 and S_WR2. Every command ends by reading the
// head (S_HEAD, S_HWAIT) before its result is shown in S_OUT. A push on a
// full pool is refused with ok low.
// One command runs at a time; the next starts in the cycle after done.
// After reset, a clearing pass chains all nodes onto the free list;
// commands queue meanwhile but are not carried out.
// Reset empties the list and the queue.
module pooled_linked_list_engine_unit #(
  parameter int POOL_NODES = pll_pkg::PoolNodesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] action,
  input  logic [7:0] item_char,
  output logic       busy,
  output logic       done,
  output logic       ok,
  output logic       hit,
  output logic [7:0] first_item,
  output logic       non_empty,
  output logic [6:0] item_count
);
  import pll_pkg::*;

  logic     cmd_valid;
  logic     cmd_take;
  pll_cmd_t cmd;

  pll_front u_front (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .item_char(item_char), .busy(busy), .cmd_valid(cmd_valid),
    .cmd(cmd), .cmd_take(cmd_take));

  pll_back #(.PoolNodes(POOL_NODES)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .done(done), .ok(ok), .hit(hit),
    .first_item(first_item), .non_empty(non_empty),
    .item_count(item_count));
endmodule

FILE: hw/rtl/pll_checker.sv
// Port-level checker for the pooled linked list engine.
module pll_checker (
  input logic       clk,
  input logic       rst,
  input logic       done,
  input logic       ok,
  input logic       hit,
  input logic [7:0] first_item,
  input logic       non_empty,
  input logic [6:0] item_count
);
  // A result shows as a single pulse of done, never held.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

  // Empty list shows zero head and zero count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    done && !non_empty |-> first_item == 8'd0 && item_count == 7'd0)
    else $error("empty list fields");

  // Non-empty list has a count.
  a_count: assert property (@(posedge clk) disable iff (rst)
    done && non_empty |-> item_count != 7'd0) else $error("count zero");

  // A hit implies ok and a non-empty list.
  a_hit: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> ok && non_empty) else $error("hit on empty");
endmodule

bind pooled_linked_list_engine_unit pll_checker u_pll_checker (
  .clk(clk), .rst(rst), .done(done), .ok(ok), .hit(hit),
  .first_item(first_item), .non_empty(non_empty), .item_count(item_count));

FILE: tb/testbench.sv
// Self-checking testbench for the pooled linked list engine unit.
`timescale 1ns / 100ps

module testbench;
  import pll_pkg::*;

  localparam int NODES = PoolNodesDefault;
  localparam int NULL_IDX = NODES;

  typedef struct {
    logic [2:0] action;
    logic [7:0] item_char;
  } list_cmd_t;

  typedef struct {
    logic       ok;
    logic       hit;
    logic [7:0] first_item;
    logic       non_empty;
    logic [6:0] item_count;
  } list_status_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic [2:0] action;
  logic [7:0] item_char;
  logic       busy;
  logic       done;
  logic       ok;
  logic       hit;
  logic [7:0] first_item;
  logic       non_empty;
  logic [6:0] item_count;

  pooled_linked_list_engine_unit uut (
    .clk(clk), .rst(rst), .start(start), .action(action), .item_char(item_char),
    .busy(busy), .done(done), .ok(ok), .hit(hit), .first_item(first_item),
    .non_empty(non_empty), .item_count(item_count)
  );

  // Shadow copy of the node pool.
  logic [7:0] shadow_items[NODES];
  int         shadow_links[NODES];
  int         shadow_head;
  int         shadow_free;
  int         shadow_count;

  list_cmd_t    pending_cmds[$];
  list_status_t expected_status[$];
  int           mismatch_count;
  int           transfer_count;
  int           hit_count;
  int           full_count;

  // Clock.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic bit node_ok(int n);
    return n >= 0 && n < NODES;
  endfunction

  function automatic void list_clear();
    for (int i = 0; i < NODES; i++) begin
      shadow_items[i] = 8'd0;
      shadow_links[i] = i + 1;
    end
    shadow_head = NULL_IDX;
    shadow_free = 0;
    shadow_count = 0;
  endfunction

  // Takes a free node; returns its index or -1 when the pool is full.
  function automatic int alloc_node(logic [7:0] ch, int link);
    int n;
    n = shadow_free;
    if (!node_ok(n)) return -1;
    shadow_free = shadow_links[n];
    shadow_items[n] = ch;
    shadow_links[n] = link;
    shadow_count++;
    return n;
  endfunction

  // Applies one command to the shadow list and returns the status it yields.
  function automatic list_status_t list_apply(list_cmd_t c);
    list_status_t s;
    int n, cur, prev, nxt, steps;
    s.ok = 1'b1;
    s.hit = 1'b0;
    case (c.action)
      ACT_PUSH_FRONT: begin
        n = alloc_node(c.item_char, shadow_head);
        if (n < 0) s.ok = 1'b0;
        else shadow_head = n;
      end
      ACT_PUSH_BACK: begin
        if (!node_ok(shadow_head)) begin
          n = alloc_node(c.item_char, shadow_head);
          if (n < 0) s.ok = 1'b0;
          else shadow_head = n;
        end else begin
          cur = shadow_head;
          steps = 0;
          while (node_ok(shadow_links[cur]) && steps < NODES) begin
            cur = shadow_links[cur];
            steps++;
          end
          n = alloc_node(c.item_char, NULL_IDX);
          if (n < 0) s.ok = 1'b0;
          else shadow_links[cur] = n;
        end
      end
      ACT_REMOVE: begin
        s.ok = 1'b0;
        prev = NULL_IDX;
        cur = shadow_head;
        steps = 0;
        while (node_ok(cur) && steps < NODES && !s.ok) begin
          if (shadow_items[cur] == c.item_char) begin
            if (node_ok(prev)) shadow_links[prev] = shadow_links[cur];
            else shadow_head = shadow_links[cur];
            shadow_items[cur] = 8'd0;
            shadow_links[cur] = shadow_free;
            shadow_free = cur;
            shadow_count--;
            s.ok = 1'b1;
          end else begin
            prev = cur;
            cur = shadow_links[cur];
            steps++;
          end
        end
      end
      ACT_FIND: begin
        cur = shadow_head;
        steps = 0;
        while (node_ok(cur) && steps < NODES && !s.hit) begin
          if (shadow_items[cur] == c.item_char) s.hit = 1'b1;
          cur = shadow_links[cur];
          steps++;
        end
      end
      ACT_REVERSE: begin
        if (node_ok(shadow_head)) begin
          prev = NULL_IDX;
          cur = shadow_head;
          steps = 0;
          while (node_ok(cur) && steps < NODES) begin
            nxt = shadow_links[cur];
            shadow_links[cur] = prev;
            prev = cur;
            cur = nxt;
            steps++;
          end
          shadow_head = prev;
        end
      end
      default: ;
    endcase
    s.non_empty = node_ok(shadow_head);
    s.first_item = s.non_empty ? shadow_items[shadow_head] : 8'd0;
    s.item_count = shadow_count[6:0];
    return s;
  endfunction

  function automatic void queue_cmd(logic [2:0] act, logic [7:0] ch);
    list_cmd_t c;
    c.action = act;
    c.item_char = ch;
    pending_cmds.push_back(c);
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    list_cmd_t c;
    list_status_t s;
    if (rst) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        c.action = action;
        c.item_char = item_char;
        s = list_apply(c);
        expected_status.push_back(s);
        transfer_count++;
        if (c.action == ACT_FIND && s.hit) hit_count++;
        if (!s.ok && c.action <= ACT_PUSH_BACK) full_count++;
      end
      if (start && busy) begin
        // Hold the pending transfer.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else begin
        c = pending_cmds.pop_front();
        action <= c.action;
        item_char <= c.item_char;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(20, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    list_status_t e;
    if (!rst && done) begin
      if (expected_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: ok=%0d hit=%0d first=%0h ne=%0d count=%0d",
                   ok, hit, first_item, non_empty, item_count);
      end else begin
        e = expected_status.pop_front();
        if (ok !== e.ok || hit !== e.hit || first_item !== e.first_item ||
            non_empty !== e.non_empty || item_count !== e.item_count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Result differs: expected ok=%0d hit=%0d first=%0h ne=%0d count=%0d",
                     e.ok, e.hit, e.first_item, e.non_empty, e.item_count);
            $display("                got      ok=%0d hit=%0d first=%0h ne=%0d count=%0d",
                     ok, hit, first_item, non_empty, item_count);
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int kind;
    int fill_target;
    logic [7:0] ch;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_PEEK;
    item_char = 8'd0;
    mismatch_count = 0;
    transfer_count = 0;
    hit_count = 0;
    full_count = 0;
    list_clear();

    // Directed: empty-list cases, extremes of the byte, unused codes.
    queue_cmd(ACT_REMOVE, 8'h00);
    queue_cmd(ACT_REVERSE, 8'hFF);
    queue_cmd(ACT_FIND, 8'h00);
    queue_cmd(ACT_PEEK, 8'hAA);
    queue_cmd(3'd6, 8'h55);
    queue_cmd(3'd7, 8'hFF);
    queue_cmd(ACT_PUSH_BACK, 8'hFF);
    queue_cmd(ACT_PUSH_FRONT, 8'h00);
    queue_cmd(ACT_PUSH_BACK, 8'h80);
    queue_cmd(ACT_FIND, 8'hFF);
    queue_cmd(ACT_FIND, 8'h7F);
    queue_cmd(ACT_REVERSE, 8'h00);
    queue_cmd(ACT_PEEK, 8'h00);
    queue_cmd(ACT_REMOVE, 8'h80);
    queue_cmd(ACT_REMOVE, 8'h12);
    queue_cmd(ACT_REMOVE, 8'hFF);
    queue_cmd(ACT_REMOVE, 8'h00);

    // Random part: phases that grow the list to full and then remove from it.
    for (int phase = 0; phase < 8; phase++) begin
      fill_target = (phase % 2 == 0) ? 70 : 50;
      for (int i = 0; i < fill_target; i++) begin
        ch = (phase < 4) ? 8'($urandom_range(15, 0)) : 8'($urandom);
        queue_cmd(3'($urandom_range(1, 0)), ch);
      end
      for (int i = 0; i < 60; i++) begin
        kind = $urandom_range(9, 0);
        if (kind < 3) queue_cmd(ACT_REMOVE, 8'($urandom_range(15, 0)));
        else if (kind < 5) queue_cmd(ACT_FIND, 8'($urandom_range(15, 0)));
        else if (kind == 5) queue_cmd(ACT_REVERSE, 8'($urandom));
        else if (kind == 6) queue_cmd(3'($urandom_range(7, 5)), 8'($urandom));
        else if (kind == 7) queue_cmd(ACT_FIND, 8'($urandom));
        else queue_cmd(3'($urandom_range(1, 0)), 8'($urandom_range(15, 0)));
      end
      for (int i = 0; i < 30; i++) queue_cmd(ACT_REMOVE, 8'($urandom_range(15, 0)));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (pending_cmds.size() == 0 && !start);
    wait (expected_status.size() == 0);
    repeat (400) @(posedge clk);
    $display("Covered %0d transfers, %0d find hits, %0d inserts refused by a full pool.",
             transfer_count, hit_count, full_count);
    if (mismatch_count == 0 && expected_status.size() == 0)
      $display("pooled_linked_list_engine_unit: match");
    else
      $display("pooled_linked_list_engine_unit: mismatch");
    $finish;
  end

  // Watchdog.
  initial begin
    #8000000;
    $display("Run timed out.");
    $display("pooled_linked_list_engine_unit: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pll_pkg.sv
hw/rtl/pll_ram.sv
hw/rtl/pll_front.sv
hw/rtl/pll_back.sv
hw/rtl/pooled_linked_list_engine_unit.sv
hw/rtl/pll_checker.sv
tb/testbench.sv
